### rtl/pocf_pkg.sv
// Shared types and constants for the payload overwrite / checksum fix core.
// Depends on nothing; every other file of the block imports it.
package pocf_pkg;

    localparam int MESSAGE_BYTES    = 64;
    localparam int MAX_PACKET_BYTES = 2048;
    localparam int MSG_AW           = (MESSAGE_BYTES > 1) ? $clog2(MESSAGE_BYTES) : 1;
    localparam int POS_W            = $clog2(MAX_PACKET_BYTES);
    localparam int CFG_W            = 11;
    localparam int CMP_W            = ((POS_W > CFG_W) ? POS_W : CFG_W) + 1;
    localparam int SUM_W            = 32;
    localparam int QUEUE_DEPTH      = 2;
    localparam int QUEUE_AW         = $clog2(QUEUE_DEPTH);
    localparam int CFG_AW           = 2;

    localparam logic MAX_ODD = 1'(MAX_PACKET_BYTES % 2);

    localparam logic [CFG_W-1:0] OFFSET_RESET = 11'd48;
    localparam logic [CFG_W-1:0] CKPOS_RESET  = 11'd22;
    localparam logic [CFG_W-1:0] SPAN_RESET   = 11'd84;

    localparam logic [CFG_AW-1:0] REG_PAYLOAD_OFFSET    = 2'd0;
    localparam logic [CFG_AW-1:0] REG_CHECKSUM_POSITION = 2'd1;
    localparam logic [CFG_AW-1:0] REG_CHECKSUM_SPAN     = 2'd2;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_PACKET = 1'b1;

    localparam logic [7:0] CKSUM_FILL = 8'hFF;

    typedef struct packed {
        logic       action;
        logic [5:0] message_index;
        logic [7:0] byte_value;
        logic       packet_last;
    } pocf_in_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_last;
        logic [15:0] checksum_value;
        logic        overlong;
    } pocf_out_t;

    typedef struct packed {
        logic [CFG_W-1:0] payload_offset;
        logic [CFG_W-1:0] checksum_position;
        logic [CFG_W-1:0] checksum_span;
    } pocf_cfg_t;

    // One resolved packet byte, handed from the front to the back.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       over;
        logic       sum_en;
        logic       odd;
        logic       pad;
    } pocf_work_t;

endpackage

### rtl/pocf_front.sv
// Front end: accepts items, owns the message store and the byte position,
// and resolves each packet byte into a work item. Depends on pocf_pkg.
module pocf_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  pocf_pkg::pocf_cfg_t cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  pocf_pkg::pocf_in_t  s_data,
    output logic                q_valid,
    input  logic                q_ready,
    output pocf_pkg::pocf_work_t q_data
);
    import pocf_pkg::*;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last;
        logic       over;
        logic       is_ck;
        logic       past_off;
        logic       in_store;
        logic       sum_en;
        logic       odd;
        logic       pad;
    } pocf_cls_t;

    logic [7:0]               store_reg [MESSAGE_BYTES];
    logic [MESSAGE_BYTES-1:0] store_vld_reg;
    logic [7:0]               rd_data_reg;
    logic                     rd_vld_reg;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             over_reg, over_next;
    logic             st_valid_reg, st_valid_next;
    pocf_cls_t        st_reg, st_next;

    logic [CMP_W-1:0] p_ext, p1, off_ext, ck_ext, span_ext, m_diff;
    logic             acc, pkt_acc, load_wr, at_end;
    logic [MSG_AW-1:0] wr_addr, rd_addr;

    assign s_ready = !st_valid_reg || q_ready;
    assign acc     = s_valid && s_ready;
    assign pkt_acc = acc && (s_data.action == ACT_PACKET);
    assign load_wr = acc && (s_data.action == ACT_LOAD)
                     && (32'(s_data.message_index) < MESSAGE_BYTES);

    assign p_ext    = CMP_W'(pos_reg);
    assign p1       = p_ext + CMP_W'(1);
    assign off_ext  = CMP_W'(cfg.payload_offset);
    assign ck_ext   = CMP_W'(cfg.checksum_position);
    assign span_ext = CMP_W'(cfg.checksum_span);
    assign m_diff   = p_ext - off_ext;
    assign at_end   = p1 >= CMP_W'(MAX_PACKET_BYTES);
    assign wr_addr  = MSG_AW'(s_data.message_index);
    assign rd_addr  = MSG_AW'(m_diff);

    always_comb begin
        st_next.byte_value = s_data.byte_value;
        st_next.last       = s_data.packet_last;
        st_next.over       = over_reg;
        st_next.is_ck      = (p_ext == ck_ext) || (p_ext == ck_ext + CMP_W'(1));
        st_next.past_off   = p_ext >= off_ext;
        st_next.in_store   = m_diff < CMP_W'(MESSAGE_BYTES);
        st_next.sum_en     = !over_reg && (p_ext < span_ext);
        st_next.odd        = pos_reg[0];
        // Parity of the number of covered bytes, min(span, packet length).
        if (over_reg) begin
            st_next.pad = (span_ext < CMP_W'(MAX_PACKET_BYTES)) ? cfg.checksum_span[0]
                                                                 : MAX_ODD;
        end else begin
            st_next.pad = (span_ext < p1) ? cfg.checksum_span[0] : !pos_reg[0];
        end
    end

    always_comb begin
        pos_next      = pos_reg;
        over_next     = over_reg;
        st_valid_next = st_valid_reg;
        if (st_valid_reg && q_ready) begin
            st_valid_next = 1'b0;
        end
        if (pkt_acc) begin
            st_valid_next = 1'b1;
            if (s_data.packet_last) begin
                pos_next  = '0;
                over_next = 1'b0;
            end else if (!over_reg) begin
                if (at_end) begin
                    over_next = 1'b1;
                end else begin
                    pos_next = p1[POS_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            over_reg      <= 1'b0;
            st_valid_reg  <= 1'b0;
            store_vld_reg <= '0;
        end else begin
            pos_reg      <= pos_next;
            over_reg     <= over_next;
            st_valid_reg <= st_valid_next;
            if (load_wr) begin
                store_vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_wr) begin
            store_reg[wr_addr] <= s_data.byte_value;
        end
        if (pkt_acc) begin
            rd_data_reg <= store_reg[rd_addr];
            rd_vld_reg  <= store_vld_reg[rd_addr];
            st_reg      <= st_next;
        end
    end

    // The checksum field wins over the payload; overlong bytes are zero.
    always_comb begin
        q_data.last   = st_reg.last;
        q_data.over   = st_reg.over;
        q_data.sum_en = st_reg.sum_en;
        q_data.odd    = st_reg.odd;
        q_data.pad    = st_reg.pad;
        priority if (st_reg.over) begin
            q_data.out_byte = '0;
        end else if (st_reg.is_ck) begin
            q_data.out_byte = CKSUM_FILL;
        end else if (st_reg.past_off) begin
            q_data.out_byte = (st_reg.in_store && rd_vld_reg) ? rd_data_reg : 8'h00;
        end else begin
            q_data.out_byte = st_reg.byte_value;
        end
    end

    assign q_valid = st_valid_reg;

endmodule

### rtl/pocf_fifo.sv
// Short queue of resolved packet bytes between the front and the back end.
// Depends on pocf_pkg.
module pocf_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pocf_pkg::pocf_work_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pocf_pkg::pocf_work_t out_data
);
    import pocf_pkg::*;

    pocf_work_t            entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;
    logic                  push, pop;

    assign in_ready  = count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

### rtl/pocf_back.sv
// Back end: accumulates the 16-bit word sum, finishes the checksum on the
// last byte of a packet and holds the result register. Depends on pocf_pkg.
module pocf_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  pocf_pkg::pocf_work_t q_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output pocf_pkg::pocf_out_t  m_data
);
    import pocf_pkg::*;

    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [7:0]       pend_reg, pend_next;
    logic             s1_valid_reg, s1_valid_next;
    logic [7:0]       s1_byte_reg;
    logic             s1_last_reg, s1_over_reg;
    logic [SUM_W-1:0] s1_total_reg;
    logic             out_valid_reg, out_valid_next;
    pocf_out_t        out_reg, out_next;

    logic             pop, s1_adv, add_word;
    logic [7:0]       pend_new;
    logic [SUM_W-1:0] addend, total;
    logic [16:0]      fold1;
    logic [15:0]      fold2;

    assign s1_adv  = !out_valid_reg || m_ready;
    assign q_ready = !s1_valid_reg || s1_adv;
    assign pop     = q_valid && q_ready;

    // A completed word and the padded odd byte never fall on the same item,
    // so one adder serves both.
    always_comb begin
        add_word = q_data.sum_en && q_data.odd;
        pend_new = (q_data.sum_en && !q_data.odd) ? q_data.out_byte : pend_reg;
        if (add_word) begin
            addend = SUM_W'({pend_reg, q_data.out_byte});
        end else if (q_data.last && q_data.pad) begin
            addend = SUM_W'({pend_new, 8'h00});
        end else begin
            addend = '0;
        end
        total = sum_reg + addend;
    end

    always_comb begin
        sum_next      = sum_reg;
        pend_next     = pend_reg;
        s1_valid_next = s1_valid_reg;
        if (s1_valid_reg && s1_adv) begin
            s1_valid_next = 1'b0;
        end
        if (pop) begin
            s1_valid_next = 1'b1;
            if (q_data.last) begin
                sum_next  = '0;
                pend_next = '0;
            end else begin
                sum_next  = total;
                pend_next = pend_new;
            end
        end
    end

    // End-around carry fold and inversion of the finished sum.
    always_comb begin
        fold1 = 17'(s1_total_reg[SUM_W-1:16]) + 17'(s1_total_reg[15:0]);
        fold2 = fold1[15:0] + 16'(fold1[16]);
        out_next.out_byte       = s1_byte_reg;
        out_next.out_last       = s1_last_reg;
        out_next.overlong       = s1_over_reg;
        out_next.checksum_value = s1_last_reg ? ~fold2 : 16'h0000;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (s1_valid_reg && s1_adv) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            pend_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            sum_reg       <= sum_next;
            pend_reg      <= pend_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            s1_byte_reg  <= q_data.out_byte;
            s1_last_reg  <= q_data.last;
            s1_over_reg  <= q_data.over;
            s1_total_reg <= total;
        end
        if (s1_valid_reg && s1_adv) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

### rtl/payload_overwrite_checksum_fix_core.sv
// Top level of the payload overwrite / checksum fix core: configuration
// registers, front end, queue and back end. Depends on pocf_pkg and pocf_*.
//
// The core rewrites streamed packet bytes, one item per cycle unless stalled.
// Load items (action 0) write one byte of the 64-byte message store and give
// no result; packet items (action 1) give exactly one result item each. From
// payload_offset on, each byte is replaced by the message byte at its distance
// from the offset (zero past the end of the store, and zero for a store entry
// never loaded since reset), and the two bytes at checksum_position are sent
// as 0xFF. The Internet checksum over the first min(checksum_span, length)
// rewritten bytes is delivered on the last result of the packet; other results
// carry zero there. Bytes past 2048 in one packet are sent as zero with
// overlong set. Both channels sustain one item per cycle when not stalled.
// A packet item's result passes four register stages: the front classify
// stage with the registered store read, the queue, the accumulate stage and
// the output register. A load takes effect at the edge that accepts it. Load
// and packet items share the input, so a load takes an input slot that a
// packet item could have used. The configuration channel is always ready;
// write it only while no item is in flight.
module payload_overwrite_checksum_fix_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  pocf_pkg::pocf_in_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output pocf_pkg::pocf_out_t         m_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [pocf_pkg::CFG_AW-1:0] cfg_index,
    input  logic [pocf_pkg::CFG_W-1:0]  cfg_data
);
    import pocf_pkg::*;

    pocf_cfg_t  cfg_reg, cfg_next;
    logic       fq_valid, fq_ready;
    pocf_work_t fq_data;
    logic       qb_valid, qb_ready;
    pocf_work_t qb_data;

    assign cfg_ready = 1'b1;

    // Writes to an index beyond the register list are accepted and dropped.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_PAYLOAD_OFFSET:    cfg_next.payload_offset    = cfg_data;
                REG_CHECKSUM_POSITION: cfg_next.checksum_position = cfg_data;
                REG_CHECKSUM_SPAN:     cfg_next.checksum_span     = cfg_data;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.payload_offset    <= OFFSET_RESET;
            cfg_reg.checksum_position <= CKPOS_RESET;
            cfg_reg.checksum_span     <= SPAN_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    pocf_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_data  (fq_data)
    );

    pocf_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    pocf_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_data  (qb_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // An overlong byte is never taken from the packet or the message store.
    a_overlong_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.overlong |-> m_data.out_byte == 8'h00)
        else $error("overlong result carries a nonzero byte");

    // Only the last byte of a packet carries a checksum.
    a_cksum_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.out_last |-> m_data.checksum_value == 16'h0000)
        else $error("checksum present on a byte that is not the last");

    // A result held for a stalled consumer does not change under it.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

endmodule

### bench/payload_overwrite_checksum_fix_core_tb.sv
// Self-checking testbench for the payload overwrite / checksum fix core.
// Depends on pocf_pkg and payload_overwrite_checksum_fix_core; it reads no data files.
module payload_overwrite_checksum_fix_core_tb;
    import pocf_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    // A load takes effect at its accepting edge, and settle waits for every packet
    // result first, so these quiet cycles leave a wide margin before the registers
    // are touched.
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_ITEMS  = 300;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    pocf_in_t          s_data    = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    pocf_out_t         m_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_AW-1:0] cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data  = '0;

    payload_overwrite_checksum_fix_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // The bench's own copy of the core state. It is advanced once for every
    // item accepted on the input channel.
    logic [7:0]  store_image [MESSAGE_BYTES];
    int unsigned next_pos;
    logic [31:0] word_sum;
    logic [7:0]  high_half;
    bit          past_limit;
    int unsigned offset_reg;
    int unsigned ckpos_reg;
    int unsigned span_reg;

    // Rewritten bytes the core still owes us, oldest first.
    pocf_out_t awaited_bytes [$];

    int mismatches     = 0;
    int cycle_count    = 0;
    int items_sent     = 0;
    int packets_sent   = 0;
    int loads_sent     = 0;
    int bytes_checked  = 0;
    int overlong_bytes = 0;
    int reg_writes     = 0;

    // Idling knobs, in percent per item, and the length of a long receiver
    // hold-off. The receiver process clears hold_cycles once it has served it.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_cycles    = 0;

    initial begin : clock_gen
        forever #2 aclk = ~aclk;
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("payload_overwrite_checksum_fix_core_tb failed");
        $finish;
    end

    function automatic void clear_packet_state();
        next_pos   = 0;
        word_sum   = '0;
        high_half  = '0;
        past_limit = 1'b0;
    endfunction

    // Applies one accepted item to the bench state. A load only updates the
    // message store. A packet byte is rewritten, folded into the running
    // checksum, and its expected result is queued.
    function automatic void rewrite_item(input pocf_in_t it);
        pocf_out_t   res;
        int unsigned pos;
        int unsigned rel;
        int unsigned len;
        int unsigned covered;
        logic [31:0] s;
        if (it.action == ACT_LOAD) begin
            store_image[it.message_index] = it.byte_value;
            return;
        end
        pos = next_pos;
        res = '0;
        res.out_last = it.packet_last;
        res.overlong = past_limit;
        if (!past_limit) begin
            res.out_byte = it.byte_value;
            if (pos >= offset_reg) begin
                rel = pos - offset_reg;
                res.out_byte = (rel < MESSAGE_BYTES) ? store_image[rel] : 8'h00;
            end
            // The checksum field wins over the payload when the two overlap.
            if (pos == ckpos_reg || pos == ckpos_reg + 1) res.out_byte = CKSUM_FILL;
            if (pos < span_reg) begin
                if (pos % 2 == 0) high_half = res.out_byte;
                else word_sum = word_sum + {16'h0, high_half, res.out_byte};
            end
        end
        if (it.packet_last) begin
            len     = past_limit ? MAX_PACKET_BYTES : pos + 1;
            covered = (span_reg < len) ? span_reg : len;
            s       = word_sum;
            // An odd count leaves a high byte waiting for a zero low byte.
            if (covered % 2 == 1) s = s + {16'h0, high_half, 8'h00};
            s = (s >> 16) + (s & 32'h0000FFFF);
            s = s + (s >> 16);
            res.checksum_value = ~s[15:0];
            clear_packet_state();
        end else if (!past_limit) begin
            // The position saturates; later bytes of this packet are overlong.
            if (pos + 1 >= MAX_PACKET_BYTES) past_limit = 1'b1;
            else next_pos = pos + 1;
        end
        if (res.overlong) overlong_bytes++;
        awaited_bytes.push_back(res);
    endfunction

    function automatic pocf_in_t make_item(input logic act, input logic [5:0] idx,
                                           input logic [7:0] val, input logic last);
        pocf_in_t it;
        it.action        = act;
        it.message_index = idx;
        it.byte_value    = val;
        it.packet_last   = last;
        return it;
    endfunction

    // Offers one item, with an optional idle burst first, and holds it steady
    // until the core takes it. Valid stays high across back-to-back items.
    task automatic send_item(input pocf_in_t it);
        if (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        rewrite_item(it);
        items_sent++;
        if (it.action == ACT_LOAD) loads_sent++;
        else if (it.packet_last) packets_sent++;
    endtask

    // Sends one packet of len bytes. Loads may be slipped in between bytes;
    // they do not advance the packet position. With extremes set, the bytes
    // alternate between all ones and all zeros.
    task automatic send_packet(input int len, input int load_pct, input bit extremes);
        logic [7:0] val;
        for (int i = 0; i < len; i++) begin
            if (load_pct > 0 && $urandom_range(1, 100) <= load_pct) begin
                send_item(make_item(ACT_LOAD, 6'($urandom), 8'($urandom), 1'($urandom)));
            end
            val = extremes ? ((i % 2 == 0) ? 8'hFF : 8'h00) : 8'($urandom);
            send_item(make_item(ACT_PACKET, 6'($urandom), val, i == len - 1));
        end
    endtask

    // Stops offering items and waits until every expected result is back,
    // then leaves the core quiet for a few more cycles.
    task automatic settle();
        s_valid <= 1'b0;
        while (awaited_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes all three registers back to back while the core is idle.
    task automatic set_registers(input int unsigned off, input int unsigned ck,
                                 input int unsigned span);
        settle();
        for (int k = 0; k < 3; k++) begin
            cfg_valid <= 1'b1;
            case (k)
                0: begin
                    cfg_index <= REG_PAYLOAD_OFFSET;
                    cfg_data  <= CFG_W'(off);
                end
                1: begin
                    cfg_index <= REG_CHECKSUM_POSITION;
                    cfg_data  <= CFG_W'(ck);
                end
                default: begin
                    cfg_index <= REG_CHECKSUM_SPAN;
                    cfg_data  <= CFG_W'(span);
                end
            endcase
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            reg_writes++;
        end
        cfg_valid  <= 1'b0;
        offset_reg = off;
        ckpos_reg  = ck;
        span_reg   = span;
    endtask

    // Result checker: every result taken from the core is matched, field by
    // field, against the oldest expectation.
    always @(posedge aclk) begin : check_results
        pocf_out_t want;
        if (aresetn && m_valid && m_ready) begin
            bytes_checked++;
            if (awaited_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result byte %02h last %0b csum %04h over %0b",
                             m_data.out_byte, m_data.out_last, m_data.checksum_value,
                             m_data.overlong);
            end else begin
                want = awaited_bytes.pop_front();
                if (m_data.out_byte !== want.out_byte || m_data.out_last !== want.out_last ||
                    m_data.checksum_value !== want.checksum_value ||
                    m_data.overlong !== want.overlong) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"ERROR: result %0d expected byte %02h last %0b csum %04h ",
                                  "over %0b, got byte %02h last %0b csum %04h over %0b"},
                                 bytes_checked, want.out_byte, want.out_last,
                                 want.checksum_value, want.overlong, m_data.out_byte,
                                 m_data.out_last, m_data.checksum_value, m_data.overlong);
                end
            end
        end
    end

    // Receiver: ready most of the time, with random stall bursts, and one long
    // hold-off on request so that the core backs up into its input.
    initial begin : receiver
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
                m_ready <= 1'b1;
            end else if (recv_stall_pct > 0 && $urandom_range(1, 100) <= recv_stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Reset values: the store is empty, so the payload region reads as zero,
    // and the checksum field sits at bytes 22 and 23.
    task automatic test_reset_defaults();
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        send_packet(52, 0, 1'b1);
    endtask

    // Payload replacement from the store, the checksum field overlapping the
    // payload, an odd span that needs padding, and payload bytes whose store
    // index runs past the end of the store.
    task automatic test_store_and_overlap();
        set_registers(0, 1, 5);
        send_item(make_item(ACT_LOAD, 6'd0, 8'hFF, 1'b1));
        send_item(make_item(ACT_LOAD, 6'd1, 8'h00, 1'b0));
        send_item(make_item(ACT_LOAD, 6'd3, 8'h5A, 1'b0));
        send_item(make_item(ACT_LOAD, 6'd4, 8'hC3, 1'b1));
        send_item(make_item(ACT_LOAD, 6'd63, 8'h81, 1'b0));
        send_packet(5, 0, 1'b1);
        // The checksum field lies far past the end of this packet.
        set_registers(0, 2046, 2047);
        send_packet(66, 0, 1'b0);
    endtask

    // One- to three-byte packets against a zero span, a span of one, and the
    // largest register values.
    task automatic test_short_packets();
        set_registers(2047, 0, 0);
        send_packet(1, 0, 1'b1);
        send_packet(2, 0, 1'b0);
        set_registers(2047, 2046, 1);
        send_packet(1, 0, 1'b1);
        send_packet(3, 0, 1'b0);
    endtask

    // A packet that overruns the maximum length by two bytes. The last two
    // allowed bytes are the checksum field, and the last one is payload too.
    task automatic test_overlong();
        send_idle_pct  = 3;
        recv_stall_pct = 3;
        set_registers(2047, 2046, 2047);
        send_packet(MAX_PACKET_BYTES + 2, 0, 1'b0);
    endtask

    // The receiver stops for a long stretch while the sender keeps offering
    // items, so the core fills up and pushes back on its input. The settle
    // after it makes the sender wait for every result.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_registers(4, 10, 60);
        hold_cycles = 200;
        send_packet(80, 10, 1'b0);
        settle();
    endtask

    // Random phases: each picks a register setting and idling rates, then runs
    // a handful of load bursts and packets. Small offsets and spans keep the
    // payload, the checksum field and the store end within short packets.
    task automatic test_random_traffic();
        int goal;
        int off;
        int ck;
        int span;
        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal) begin
            case ($urandom_range(0, 5))
                0: begin
                    off  = 0;
                    ck   = 0;
                    span = 0;
                end
                1: begin
                    off  = 2047;
                    ck   = 2046;
                    span = 2047;
                end
                default: begin
                    off  = $urandom_range(0, 60);
                    ck   = $urandom_range(0, 90);
                    span = $urandom_range(0, 110);
                end
            endcase
            set_registers(off, ck, span);
            // The tail of the run is free of idling on both sides.
            if (goal - items_sent < 250) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end else begin
                send_idle_pct  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
                recv_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
            end
            repeat ($urandom_range(4, 10)) begin
                // Loads mostly hit the low entries, which short packets read.
                repeat ($urandom_range(0, 8)) begin
                    send_item(make_item(ACT_LOAD,
                                        ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 15))
                                                                   : 6'($urandom),
                                        8'($urandom), 1'($urandom)));
                end
                if ($urandom_range(0, 9) != 0)
                    send_packet($urandom_range(1, 100), 5, $urandom_range(0, 15) == 0);
            end
        end
    endtask

    initial begin : run_tests
        foreach (store_image[i]) store_image[i] = 8'h00;
        clear_packet_state();
        offset_reg = OFFSET_RESET;
        ckpos_reg  = CKPOS_RESET;
        span_reg   = SPAN_RESET;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_store_and_overlap();
        test_short_packets();
        test_overlong();
        test_backpressure();
        test_random_traffic();
        settle();

        $display("Run covered %0d packets and %0d message loads; %0d result items checked,",
                 packets_sent, loads_sent, bytes_checked);
        $display("%0d of them overlong, across %0d register writes and %0d mismatches.",
                 overlong_bytes, reg_writes, mismatches);
        if (mismatches == 0) begin
            $display("payload_overwrite_checksum_fix_core_tb passed");
        end else begin
            $display("payload_overwrite_checksum_fix_core_tb failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/pocf_pkg.sv
rtl/pocf_front.sv
rtl/pocf_fifo.sv
rtl/pocf_back.sv
rtl/payload_overwrite_checksum_fix_core.sv
bench/payload_overwrite_checksum_fix_core_tb.sv
